@@ sv/ipsl_pkg.sv @@
// Package for the incremental PID speed loop: field widths, register indexes,
// and register reset values. No dependencies.
`default_nettype none

package ipsl_pkg;

   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 31;
   localparam int ACC_W    = 32;
   localparam int ADJUST_W = 23;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [GAIN_W-1:0]  GAIN_P_RESET    = 16'd512;
   localparam logic [GAIN_W-1:0]  GAIN_I_RESET    = 16'd0;
   localparam logic [GAIN_W-1:0]  GAIN_D_RESET    = 16'd81;
   localparam logic [LIMIT_W-1:0] OUT_LIMIT_RESET = 31'd4096000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P      = 3'd0,
      CSR_GAIN_I      = 3'd1,
      CSR_GAIN_D      = 3'd2,
      CSR_OUT_LIMIT   = 3'd3,
      CSR_LOOP_ENABLE = 3'd4
   } csr_index_type;

endpackage

`default_nettype wire

@@ sv/incremental_pid_speed_loop_unit.sv @@
// Top level of the incremental PID speed loop: stream input, stream result,
// register write port. Depends on ipsl_pkg.
`default_nettype none

// One channel of a velocity-form PID with Q10 gains. Each request transaction
// carries a setpoint and a measured speed; each produces exactly one response
// transaction with adjust = -(clamp(acc, +-out_limit) >>> FRAC_BITS), where acc
// gains kp*(e-e1) + ki*e + kd*(e-2e1+e2) per item and saturates at 32 bits signed.
// A new transaction is taken every cycle unless a stalled output fills the pipeline;
// each passes the input, product, accumulator and adjust registers in turn. The
// rate is set by the accumulator add and saturate feeding acc_ff back; the three
// gain products are formed one stage earlier in parallel multipliers. With loop_enable
// at 0 each item returns 0 and clears the accumulator and error history. Write
// registers only while no transaction is in flight; csr_ready is always high.
module incremental_pid_speed_loop_unit #(
   parameter int SPEED_WIDTH = 16,
   parameter int FRAC_BITS   = 10
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // fields from bit 0: setpoint, measured, zero pad
   input  wire logic [((2*SPEED_WIDTH+7)/8)*8-1:0]  req_tdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // fields from bit 0: adjust, zero pad
   output logic [((ipsl_pkg::ADJUST_W+7)/8)*8-1:0]  rsp_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic [ipsl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ipsl_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready
);
   import ipsl_pkg::*;

   localparam int SW     = SPEED_WIDTH;
   localparam int ERR_W  = SW + 1;
   localparam int D1_W   = SW + 2;
   localparam int D2_W   = SW + 3;
   localparam int PP_W   = GAIN_W + 1 + D1_W;
   localparam int PI_W   = GAIN_W + 1 + ERR_W;
   localparam int PD_W   = GAIN_W + 1 + D2_W;
   localparam int SUM_W  = ((ACC_W > PD_W) ? ACC_W : PD_W) + 2;
   localparam int CL_W   = ACC_W + 1;
   localparam int RSP_W  = ((ADJUST_W + 7) / 8) * 8;

   localparam logic signed [SUM_W-1:0] SAT_HI =
      {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO =
      {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

   // registers
   logic [GAIN_W-1:0]  gain_p_ff, gain_i_ff, gain_d_ff;
   logic [LIMIT_W-1:0] out_limit_ff;
   logic               loop_enable_ff;

   logic                  s1_valid_ff;
   logic signed [SW-1:0]  setpoint_ff, measured_ff;
   logic                  s2_valid_ff;
   logic signed [PP_W-1:0] prod_p_ff;
   logic signed [PI_W-1:0] prod_i_ff;
   logic signed [PD_W-1:0] prod_d_ff;
   logic signed [ERR_W-1:0] prev_error_ff, prev2_error_ff;
   logic                  s3_valid_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic                  rsp_valid_ff;
   logic [ADJUST_W-1:0]   adjust_ff;

   // flow control
   logic adv1, adv2, adv3, adv4;
   logic load1, load2, load3, load4;

   assign adv4  = !rsp_valid_ff || rsp_tready;
   assign adv3  = !s3_valid_ff || adv4;
   assign adv2  = !s2_valid_ff || adv3;
   assign adv1  = !s1_valid_ff || adv2;
   assign load1 = req_tvalid && adv1;
   assign load2 = s1_valid_ff && adv2;
   assign load3 = s2_valid_ff && adv3;
   assign load4 = s3_valid_ff && adv4;

   assign req_tready = adv1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-ADJUST_W){1'b0}}, adjust_ff};
   assign csr_ready  = 1'b1;

   // error terms and gain products
   logic signed [ERR_W-1:0]  error_in;
   logic signed [D1_W-1:0]   diff1;
   logic signed [D2_W-1:0]   diff2;
   logic signed [GAIN_W:0]   gp_s, gi_s, gd_s;
   logic signed [PP_W-1:0]   prod_p_in;
   logic signed [PI_W-1:0]   prod_i_in;
   logic signed [PD_W-1:0]   prod_d_in;

   always_comb begin
      error_in = $signed({measured_ff[SW-1], measured_ff})
               - $signed({setpoint_ff[SW-1], setpoint_ff});
      diff1 = $signed({error_in[ERR_W-1], error_in})
            - $signed({prev_error_ff[ERR_W-1], prev_error_ff});
      diff2 = $signed({{2{error_in[ERR_W-1]}}, error_in})
            - $signed({prev_error_ff[ERR_W-1], prev_error_ff, 1'b0})
            + $signed({{2{prev2_error_ff[ERR_W-1]}}, prev2_error_ff});
      gp_s = $signed({1'b0, gain_p_ff});
      gi_s = $signed({1'b0, gain_i_ff});
      gd_s = $signed({1'b0, gain_d_ff});
      prod_p_in = gp_s * diff1;
      prod_i_in = gi_s * error_in;
      prod_d_in = gd_s * diff2;
   end

   // accumulate and saturate
   logic signed [SUM_W-1:0] sum_full;
   logic signed [ACC_W-1:0] acc_in;

   always_comb begin
      sum_full = $signed({{(SUM_W-ACC_W){acc_ff[ACC_W-1]}}, acc_ff})
               + $signed({{(SUM_W-PP_W){prod_p_ff[PP_W-1]}}, prod_p_ff})
               + $signed({{(SUM_W-PI_W){prod_i_ff[PI_W-1]}}, prod_i_ff})
               + $signed({{(SUM_W-PD_W){prod_d_ff[PD_W-1]}}, prod_d_ff});
      if (sum_full > SAT_HI) begin
         acc_in = SAT_HI[ACC_W-1:0];
      end else if (sum_full < SAT_LO) begin
         acc_in = SAT_LO[ACC_W-1:0];
      end else begin
         acc_in = sum_full[ACC_W-1:0];
      end
   end

   // clamp, shift, negate
   logic signed [CL_W-1:0] acc_x, lim_pos, lim_neg, clamped, shifted, negated;

   always_comb begin
      acc_x   = $signed({acc_ff[ACC_W-1], acc_ff});
      lim_pos = $signed({{(CL_W-LIMIT_W){1'b0}}, out_limit_ff});
      lim_neg = -lim_pos;
      if (acc_x > lim_pos) begin
         clamped = lim_pos;
      end else if (acc_x < lim_neg) begin
         clamped = lim_neg;
      end else begin
         clamped = acc_x;
      end
      shifted = clamped >>> FRAC_BITS;
      negated = -shifted;
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff      <= GAIN_P_RESET;
         gain_i_ff      <= GAIN_I_RESET;
         gain_d_ff      <= GAIN_D_RESET;
         out_limit_ff   <= OUT_LIMIT_RESET;
         loop_enable_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GAIN_P:      gain_p_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:      gain_i_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:      gain_d_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_OUT_LIMIT:   out_limit_ff   <= csr_wdata[LIMIT_W-1:0];
            CSR_LOOP_ENABLE: loop_enable_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // pipeline valids and state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         prev_error_ff  <= '0;
         prev2_error_ff <= '0;
         acc_ff         <= '0;
      end else begin
         if (adv1) s1_valid_ff  <= req_tvalid;
         if (adv2) s2_valid_ff  <= s1_valid_ff;
         if (adv3) s3_valid_ff  <= s2_valid_ff;
         if (adv4) rsp_valid_ff <= s3_valid_ff;
         if (load2) begin
            if (loop_enable_ff) begin
               prev_error_ff  <= error_in;
               prev2_error_ff <= prev_error_ff;
            end else begin
               prev_error_ff  <= '0;
               prev2_error_ff <= '0;
            end
         end
         if (load3) begin
            acc_ff <= loop_enable_ff ? acc_in : '0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load1) begin
         setpoint_ff <= $signed(req_tdata[SW-1:0]);
         measured_ff <= $signed(req_tdata[2*SW-1:SW]);
      end
      if (load2) begin
         prod_p_ff <= loop_enable_ff ? prod_p_in : '0;
         prod_i_ff <= loop_enable_ff ? prod_i_in : '0;
         prod_d_ff <= loop_enable_ff ? prod_d_in : '0;
      end
      if (load4) begin
         adjust_ff <= negated[ADJUST_W-1:0];
      end
   end

`ifndef SYNTH
   a_ready_when_drain: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || rsp_tready) |-> req_tready)
      else $error("input not ready while output can drain");

   a_hist_cleared: assert property (@(posedge clock) disable iff (reset)
      (load2 && !loop_enable_ff) |=> (prev_error_ff == '0 && prev2_error_ff == '0))
      else $error("error history not cleared while disabled");

   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      (load3 && !loop_enable_ff) |=> (acc_ff == '0))
      else $error("accumulator not cleared while disabled");

   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      !load3 |=> $stable(acc_ff))
      else $error("accumulator changed without a transaction");
`endif

endmodule

`default_nettype wire
